### design/dvc_pkg.sv
// shared constants and types of the duplicate value counter
// no dependencies; used by every other file of the block
`default_nettype none

package dvc_pkg;

    localparam int VALUE_W         = 7;
    localparam int COUNT_W         = 8;
    localparam int TALLY_W         = VALUE_W + 1;
    localparam int MAX_RESULTS     = 64;
    localparam int VALUE_COUNT_DEF = 128;
    localparam int MAX_ITEMS_DEF   = 128;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_LOAD,
        ST_WALK_ORD,
        ST_WALK_CNT,
        ST_WALK_EVAL
    } t_state;

endpackage

`default_nettype wire

### design/dvc_count_store.sv
// occurrence count memory: one read and one write port, registered read data
// read-during-write to the same entry returns the new data; uses dvc_pkg
`default_nettype none

module dvc_count_store #(
    parameter int DEPTH = dvc_pkg::VALUE_COUNT_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rd_en,
    input  wire logic [AW-1:0]               i_rd_addr,
    input  wire logic                        i_wr_en,
    input  wire logic [AW-1:0]               i_wr_addr,
    input  wire logic [dvc_pkg::COUNT_W-1:0] i_wr_data,
    output logic      [dvc_pkg::COUNT_W-1:0] o_rd_data
);

    logic [dvc_pkg::COUNT_W-1:0] r_mem [DEPTH];
    logic [dvc_pkg::COUNT_W-1:0] r_rd_data;
    logic [dvc_pkg::COUNT_W-1:0] r_fwd_data;
    logic                        r_fwd_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_fwd_hit  <= i_wr_en && (i_wr_addr == i_rd_addr);
            r_fwd_data <= i_wr_data;
        end
    end

    // bypass of a write that landed on the entry being read
    assign o_rd_data = r_fwd_hit ? r_fwd_data : r_rd_data;

endmodule

`default_nettype wire

### design/duplicate_value_counter_unit.sv
// top level of the duplicate value counter: load pipeline, report walk, output register
// depends on dvc_pkg and dvc_count_store
`default_nettype none

// A set of values arrives one element per transfer, the last one flagged by
// i_final_item. While a set loads, one element is taken every cycle: the count
// of the value is read from the count memory in the cycle of the transfer and
// written back in the next cycle, with a bypass when consecutive elements hit
// the same value. Once the final element has been taken, the input stalls for
// the report walk: the first-appearance list is walked one entry at a time in
// three steps (list read, count read, evaluate and clear the count), so the
// input stays held until every distinct value has been visited; a stalled
// output holds the evaluate step. Each value seen at least twice gives one
// result transfer, in order of first appearance, at most 64 per set, the last
// one flagged by o_last_of_run; o_truncated reports that elements beyond
// MAX_ITEMS were dropped. Values at or above VALUE_COUNT are ignored and counts
// saturate at 255. After reset a clearing pass zeroes the first min(VALUE_COUNT,
// 128) entries of the count memory, during which the input stalls. The walk
// clears every count it visits, so the next set starts clean.

module duplicate_value_counter_unit #(
    parameter int VALUE_COUNT = dvc_pkg::VALUE_COUNT_DEF,
    parameter int MAX_ITEMS   = dvc_pkg::MAX_ITEMS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // input channel
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [dvc_pkg::VALUE_W-1:0] i_value,
    input  wire logic                        i_final_item,
    // result channel
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic      [dvc_pkg::VALUE_W-1:0] o_repeated_value,
    output logic      [dvc_pkg::COUNT_W-1:0] o_occurrences,
    output logic                             o_last_of_run,
    output logic                             o_truncated
);

    localparam int AW        = $clog2(VALUE_COUNT);
    localparam int IW        = $clog2(MAX_ITEMS + 1);
    localparam int TW        = dvc_pkg::TALLY_W;
    // only values below 2**VALUE_W can ever reach the memory
    localparam int REACHABLE = 2 ** dvc_pkg::VALUE_W;
    localparam int CLR_DEPTH = (VALUE_COUNT < REACHABLE) ? VALUE_COUNT : REACHABLE;
    localparam int CLRW      = $clog2(CLR_DEPTH);

    // state machine
    dvc_pkg::t_state r_state;
    dvc_pkg::t_state n_state;

    // load pipeline, second stage
    logic                        r_s1_vld;
    logic                        r_s1_fin;
    logic [dvc_pkg::VALUE_W-1:0] r_s1_value;

    // set bookkeeping
    logic [TW-1:0]   r_distinct;
    logic [TW-1:0]   r_repeat;
    logic [IW-1:0]   r_items;
    logic            r_overflow;

    // walk and clearing pass
    logic [TW-1:0]   r_idx;
    logic [TW-1:0]   r_emitted;
    logic [CLRW-1:0] r_clr_idx;

    // first-appearance list
    logic [dvc_pkg::VALUE_W-1:0] r_order_mem [VALUE_COUNT];
    logic [dvc_pkg::VALUE_W-1:0] r_ord_data;

    // output register
    logic                        r_out_vld;
    logic [dvc_pkg::VALUE_W-1:0] r_out_value;
    logic [dvc_pkg::COUNT_W-1:0] r_out_count;
    logic                        r_out_last;
    logic                        r_out_trunc;

    // count memory ports
    logic                        cnt_rd_en;
    logic [AW-1:0]               cnt_rd_addr;
    logic                        cnt_wr_en;
    logic [AW-1:0]               cnt_wr_addr;
    logic [dvc_pkg::COUNT_W-1:0] cnt_wr_data;
    logic [dvc_pkg::COUNT_W-1:0] cnt_rd_data;

    // control
    logic in_accept;
    logic s1_in_range;
    logic s1_full;
    logic s1_take;
    logic s1_first;
    logic s1_end;
    logic [dvc_pkg::COUNT_W-1:0] s1_new_count;
    logic [TW-1:0] want;
    logic walk_emit;
    logic out_free;
    logic eval_go;
    logic walk_done;
    logic ord_rd_en;
    logic ord_wr_en;
    logic emit_load;
    logic clr_last;

    assign in_accept = i_in_valid && !o_in_stall;

    // element in the second stage: capacity first, then value range
    assign s1_full      = (r_items >= IW'(MAX_ITEMS));
    assign s1_in_range  = (32'(r_s1_value) < VALUE_COUNT);
    assign s1_take      = r_s1_vld && !s1_full && s1_in_range;
    assign s1_first     = (cnt_rd_data == '0);
    assign s1_new_count = (cnt_rd_data == dvc_pkg::COUNT_MAX) ? cnt_rd_data
                                                              : cnt_rd_data + 1'b1;
    assign s1_end       = r_s1_vld && r_s1_fin;

    // report walk decisions
    assign want      = (r_repeat > TW'(dvc_pkg::MAX_RESULTS)) ? TW'(dvc_pkg::MAX_RESULTS)
                                                              : r_repeat;
    assign walk_emit = (cnt_rd_data >= dvc_pkg::COUNT_W'(2)) && (r_emitted < want);
    assign out_free  = !r_out_vld || !i_out_stall;
    assign eval_go   = !walk_emit || out_free;
    assign walk_done = (r_idx == r_distinct);
    assign clr_last  = (r_clr_idx == CLRW'(CLR_DEPTH - 1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dvc_pkg::ST_CLEAR: begin
                if (clr_last) begin
                    n_state = dvc_pkg::ST_LOAD;
                end
            end
            dvc_pkg::ST_LOAD: begin
                if (s1_end) begin
                    n_state = dvc_pkg::ST_WALK_ORD;
                end
            end
            dvc_pkg::ST_WALK_ORD: begin
                n_state = walk_done ? dvc_pkg::ST_LOAD : dvc_pkg::ST_WALK_CNT;
            end
            dvc_pkg::ST_WALK_CNT: begin
                n_state = dvc_pkg::ST_WALK_EVAL;
            end
            dvc_pkg::ST_WALK_EVAL: begin
                if (eval_go) begin
                    n_state = dvc_pkg::ST_WALK_ORD;
                end
            end
            default: begin
                n_state = dvc_pkg::ST_CLEAR;
            end
        endcase
    end

    // state outputs: memory ports and strobes
    always_comb begin
        o_in_stall  = 1'b1;
        cnt_rd_en   = 1'b0;
        cnt_rd_addr = AW'(i_value);
        cnt_wr_en   = 1'b0;
        cnt_wr_addr = AW'(r_s1_value);
        cnt_wr_data = s1_new_count;
        ord_rd_en   = 1'b0;
        ord_wr_en   = 1'b0;
        emit_load   = 1'b0;
        case (r_state)
            dvc_pkg::ST_CLEAR: begin
                cnt_wr_en   = 1'b1;
                cnt_wr_addr = AW'(r_clr_idx);
                cnt_wr_data = '0;
            end
            dvc_pkg::ST_LOAD: begin
                // hold the input once the final element is in the second stage
                o_in_stall = s1_end;
                cnt_rd_en  = in_accept;
                cnt_wr_en  = s1_take;
                ord_wr_en  = s1_take && s1_first;
            end
            dvc_pkg::ST_WALK_ORD: begin
                ord_rd_en = !walk_done;
            end
            dvc_pkg::ST_WALK_CNT: begin
                cnt_rd_en   = 1'b1;
                cnt_rd_addr = AW'(r_ord_data);
            end
            dvc_pkg::ST_WALK_EVAL: begin
                // clear the visited count as the entry is retired
                cnt_wr_en   = eval_go;
                cnt_wr_addr = AW'(r_ord_data);
                cnt_wr_data = '0;
                emit_load   = walk_emit && out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    dvc_count_store #(
        .DEPTH (VALUE_COUNT),
        .AW    (AW)
    ) u_count_store (
        .i_clk     (i_clk),
        .i_rd_en   (cnt_rd_en),
        .i_rd_addr (cnt_rd_addr),
        .i_wr_en   (cnt_wr_en),
        .i_wr_addr (cnt_wr_addr),
        .i_wr_data (cnt_wr_data),
        .o_rd_data (cnt_rd_data)
    );

    // first-appearance list, undefined until written
    always_ff @(posedge i_clk) begin
        if (ord_wr_en) begin
            r_order_mem[AW'(r_distinct)] <= r_s1_value;
        end
        if (ord_rd_en) begin
            r_ord_data <= r_order_mem[AW'(r_idx)];
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dvc_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // load pipeline: element registered alongside its count read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_value <= i_value;
            r_s1_fin   <= i_final_item;
        end
    end

    // set bookkeeping, walk index and clearing counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_distinct <= '0;
            r_repeat   <= '0;
            r_items    <= '0;
            r_overflow <= 1'b0;
            r_idx      <= '0;
            r_emitted  <= '0;
            r_clr_idx  <= '0;
        end else begin
            if (r_state == dvc_pkg::ST_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (r_state == dvc_pkg::ST_LOAD && r_s1_vld) begin
                if (s1_full) begin
                    r_overflow <= 1'b1;
                end else if (s1_in_range) begin
                    r_items <= r_items + 1'b1;
                    if (s1_first) begin
                        r_distinct <= r_distinct + 1'b1;
                    end
                    // count reaching two marks a new repeated value
                    if (cnt_rd_data == dvc_pkg::COUNT_W'(1)) begin
                        r_repeat <= r_repeat + 1'b1;
                    end
                end
            end
            if (r_state == dvc_pkg::ST_WALK_EVAL && eval_go) begin
                r_idx <= r_idx + 1'b1;
                if (walk_emit) begin
                    r_emitted <= r_emitted + 1'b1;
                end
            end
            // end of walk: ready for the next set
            if (r_state == dvc_pkg::ST_WALK_ORD && walk_done) begin
                r_distinct <= '0;
                r_repeat   <= '0;
                r_items    <= '0;
                r_overflow <= 1'b0;
                r_idx      <= '0;
                r_emitted  <= '0;
            end
        end
    end

    // output register, held while the result side stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (emit_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_load) begin
            r_out_value <= r_ord_data;
            r_out_count <= cnt_rd_data;
            r_out_last  <= (r_emitted + 1'b1 == want);
            r_out_trunc <= r_overflow;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_repeated_value = r_out_value;
    assign o_occurrences    = r_out_count;
    assign o_last_of_run    = r_out_last;
    assign o_truncated      = r_out_trunc;

endmodule

`default_nettype wire

### design/dvc_checker.sv
// port-level checks of the duplicate value counter and their binding
// depends on dvc_pkg and duplicate_value_counter_unit
`default_nettype none

module dvc_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_valid,
    input wire logic                        o_in_stall,
    input wire logic                        i_final_item,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_stall,
    input wire logic [dvc_pkg::VALUE_W-1:0] o_repeated_value,
    input wire logic [dvc_pkg::COUNT_W-1:0] o_occurrences,
    input wire logic                        o_last_of_run,
    input wire logic                        o_truncated
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_repeated_value)
            && $stable(o_occurrences) && $stable(o_last_of_run) && $stable(o_truncated))
        else $error("result changed while stalled");

    // only repeated values are reported
    a_count_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_occurrences >= dvc_pkg::COUNT_W'(2))
        else $error("reported value occurred fewer than two times");

    // the end of a set stops the input for the report
    a_final_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_final_item |=> o_in_stall)
        else $error("input taken right after the final element");

    // reset starts the clearing pass with nothing to report
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_stall)
        else $error("block not quiet after reset");

endmodule

bind duplicate_value_counter_unit dvc_checker u_dvc_checker (.*);

`default_nettype wire
